### sv/fgn_pkg.sv
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared types, register codes and defaults for the layered gradient noise.
// ----------------------------------------------------------------------------
package fgn_pkg;

    localparam int MAX_OCTAVES_DEF     = 8;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int SUM_W    = 40;
    localparam int AMPSUM_W = 21;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_FRACTAL = 2'd0;
    localparam mode_t MODE_TURB    = 2'd1;
    localparam mode_t MODE_RIDGED  = 2'd2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_MODE   = 3'd0;
    localparam reg_idx_t REG_OCT    = 3'd1;
    localparam reg_idx_t REG_LAC    = 3'd2;
    localparam reg_idx_t REG_GAIN   = 3'd3;
    localparam reg_idx_t REG_RIDGE  = 3'd4;
    localparam reg_idx_t REG_SEED   = 3'd5;

    // live configuration, octave count already limited to the unit count
    typedef struct packed {
        mode_t        mode;
        logic [4:0]   oct;
        logic [15:0]  lac;
        logic [15:0]  gain;
        logic [14:0]  ridge;
        logic [31:0]  seed;
    } cfg_t;

    // running state of one sample between octaves
    typedef struct packed {
        logic signed [31:0]         x;
        logic signed [31:0]         z;
        logic [30:0]                freq;
        logic [16:0]                amp;
        logic [18:0]                prev;
        logic signed [SUM_W-1:0]    sum;
        logic [AMPSUM_W-1:0]        ampsum;
    } acc_t;

endpackage

### sv/fgn_octave.sv
// ----------------------------------------------------------------------------
// fgn_octave
// One octave: scale, lattice hash, smootherstep, blend and accumulate.
// ----------------------------------------------------------------------------
module fgn_octave
    import fgn_pkg::*;
#(
    parameter int IDX             = 0,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  cfg_t  cfg,
    input  logic  in_valid,
    input  acc_t  in_acc,
    output logic  out_valid,
    output acc_t  out_acc
);

    localparam logic [31:0] HASH_C1 = 32'h9e3779b9;
    localparam logic [31:0] HASH_C2 = 32'h85ebca6b;
    localparam logic [31:0] HASH_C3 = 32'hc2b2ae35;
    localparam logic [31:0] HASH_C4 = 32'h7feb352d;
    localparam logic [31:0] HASH_C5 = 32'h846ca68b;

    localparam logic [2:0] GRAD_PX   = 3'd0;
    localparam logic [2:0] GRAD_NX   = 3'd1;
    localparam logic [2:0] GRAD_PZ   = 3'd2;
    localparam logic [2:0] GRAD_NZ   = 3'd3;
    localparam logic [2:0] GRAD_DSUM = 3'd4;
    localparam logic [2:0] GRAD_DZX  = 3'd5;
    localparam logic [2:0] GRAD_DXZ  = 3'd6;
    localparam logic [2:0] GRAD_DNEG = 3'd7;

    localparam int NST = 15;

    function automatic logic [31:0] hash_mix(input logic [31:0] h, input logic [31:0] v,
                                             input logic [31:0] c);
        hash_mix = h ^ (v + c + (h << 6) + (h >> 2));
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
        begin
            sat32 = 32'sh7FFFFFFF;
        end
        else if (v < -48'sd2147483648)
        begin
            sat32 = 32'sh80000000;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic [15:0] frac_q16(input logic signed [31:0] s);
        logic [47:0] f;
        f = 48'(s[COORD_FRAC_BITS-1:0]) << 16;
        frac_q16 = 16'(f >> COORD_FRAC_BITS);
    endfunction

    logic [NST:1] vld_reg;
    acc_t         acc_reg [1:NST-1];
    acc_t         acc_out_reg;

    // stage 1
    logic signed [63:0] px_reg, pz_reg;
    // stage 2
    logic [31:0]        x0_reg, x1_reg, z0_reg, z1_reg;
    logic [15:0]        tx_reg [2:6];
    logic [15:0]        tz_reg [2:6];
    // stage 3
    logic [31:0]        h1x0_reg, h1x1_reg, z0d_reg, z1d_reg;
    logic signed [37:0] p1x_reg, p1z_reg;
    // stages 4 to 6
    logic [31:0]        h4_reg [0:3];
    logic [31:0]        h5_reg [0:3];
    logic [31:0]        h6_reg [0:3];
    logic signed [39:0] p2x_reg, p2z_reg, p3x_reg, p3z_reg, p4x_reg, p4z_reg;
    // stage 7
    logic signed [18:0] s_reg  [0:3];
    logic               dg_reg [0:3];
    logic signed [35:0] pd_reg [0:3];
    logic [16:0]        u_reg, v7_reg;
    // stages 8 to 11
    logic signed [19:0] g00_reg, g01_reg;
    logic signed [37:0] bl0_reg, bl1_reg;
    logic [16:0]        v8_reg;
    logic signed [19:0] ax_reg;
    logic signed [38:0] bly_reg;
    logic signed [37:0] rq_reg;
    logic signed [17:0] n_reg;
    // stages 12 to 14
    logic signed [37:0] pr12_reg;
    logic [18:0]        n2_13_reg, n2_14_reg;
    logic signed [39:0] term13_reg, term14_reg;
    logic [46:0]        fp_reg;
    logic [32:0]        ap_reg;

    logic ridged, turb;
    assign ridged = (cfg.mode == MODE_RIDGED);
    assign turb   = (cfg.mode == MODE_TURB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-1:1], in_valid};
        end
    end

    // ---------------- combinational stage logic ----------------
    logic signed [63:0] px_next, pz_next;
    logic signed [31:0] sx, sz;
    logic [31:0]        x0_next, z0_next;
    logic [31:0]        hs;
    logic signed [20:0] ax6, az6;
    logic signed [37:0] p1x_next, p1z_next;
    logic [31:0]        h2 [0:3];
    logic signed [21:0] b1x, b1z;
    logic signed [39:0] p2x_next, p2z_next, p3x_next, p3z_next, p4x_next, p4z_next;
    logic [31:0]        h7 [0:3];
    logic signed [18:0] ca, cb;
    logic signed [18:0] s_next [0:3];
    logic               dg_next [0:3];
    logic signed [35:0] pd_next [0:3];
    logic signed [21:0] b4x, b4z;
    logic [16:0]        u_next, v_next;
    logic signed [18:0] g [0:3];
    logic signed [19:0] dx0, dx1;
    logic signed [19:0] ax_next, bx;
    logic signed [20:0] dy;
    logic signed [19:0] r;
    logic signed [37:0] rr;
    logic signed [17:0] n_next, an;
    logic signed [18:0] d, opa, opb;
    logic [18:0]        n2;
    logic [35:0]        t1;
    logic [38:0]        t2;
    logic [33:0]        fq;
    acc_t               acc_next;

    always_comb
    begin
        // stage 1: scale the point by the octave frequency
        px_next = in_acc.x * $signed({1'b0, in_acc.freq});
        pz_next = in_acc.z * $signed({1'b0, in_acc.freq});

        // stage 2: saturate, split lattice cell and offset
        sx      = sat32(48'(px_reg >>> 16));
        sz      = sat32(48'(pz_reg >>> 16));
        x0_next = sx >>> COORD_FRAC_BITS;
        z0_next = sz >>> COORD_FRAC_BITS;

        // stage 3: hash front over x, first smootherstep product
        hs       = cfg.seed + 32'(IDX) + HASH_C1;
        ax6      = $signed(21'(tx_reg[2]) * 21'd6) - 21'sd983040;
        az6      = $signed(21'(tz_reg[2]) * 21'd6) - 21'sd983040;
        p1x_next = ax6 * $signed({1'b0, tx_reg[2]});
        p1z_next = az6 * $signed({1'b0, tz_reg[2]});

        // stage 4: hash over z, four corners in order 00, 10, 01, 11
        h2[0] = hash_mix(h1x0_reg, z0d_reg, HASH_C3);
        h2[1] = hash_mix(h1x1_reg, z0d_reg, HASH_C3);
        h2[2] = hash_mix(h1x0_reg, z1d_reg, HASH_C3);
        h2[3] = hash_mix(h1x1_reg, z1d_reg, HASH_C3);
        b1x      = 22'(p1x_reg >>> 16) + 22'sd655360;
        b1z      = 22'(p1z_reg >>> 16) + 22'sd655360;
        p2x_next = b1x * $signed({1'b0, tx_reg[3]});
        p2z_next = b1z * $signed({1'b0, tz_reg[3]});

        // stages 5 and 6: remaining Horner steps
        p3x_next = $signed(22'(p2x_reg >>> 16)) * $signed({1'b0, tx_reg[4]});
        p3z_next = $signed(22'(p2z_reg >>> 16)) * $signed({1'b0, tz_reg[4]});
        p4x_next = $signed(22'(p3x_reg >>> 16)) * $signed({1'b0, tx_reg[5]});
        p4z_next = $signed(22'(p3z_reg >>> 16)) * $signed({1'b0, tz_reg[5]});

        // stage 7: finish hash, pick gradient, clamp weights
        for (int c = 0; c < 4; c++)
        begin
            h7[c] = h6_reg[c] ^ (h6_reg[c] >> 16);
            ca = $signed({3'b000, tx_reg[6]});
            cb = $signed({3'b000, tz_reg[6]});
            if (c[0])
            begin
                ca = ca - 19'sd65536;
            end
            if (c[1])
            begin
                cb = cb - 19'sd65536;
            end
            dg_next[c] = h7[c][2];
            unique case (h7[c][2:0])
                GRAD_PX:   s_next[c] = ca;
                GRAD_NX:   s_next[c] = -ca;
                GRAD_PZ:   s_next[c] = cb;
                GRAD_NZ:   s_next[c] = -cb;
                GRAD_DSUM: s_next[c] = ca + cb;
                GRAD_DZX:  s_next[c] = cb - ca;
                GRAD_DXZ:  s_next[c] = ca - cb;
                GRAD_DNEG: s_next[c] = -ca - cb;
            endcase
            pd_next[c] = s_next[c] * 36'sd46341;
        end
        b4x = 22'(p4x_reg >>> 16);
        b4z = 22'(p4z_reg >>> 16);
        u_next = (b4x < 0) ? 17'd0 : ((b4x > 22'sd65536) ? 17'd65536 : 17'(b4x));
        v_next = (b4z < 0) ? 17'd0 : ((b4z > 22'sd65536) ? 17'd65536 : 17'(b4z));

        // stage 8: round diagonals, blend along x
        for (int c = 0; c < 4; c++)
        begin
            g[c] = dg_reg[c] ? 19'((pd_reg[c] + 36'sd32768) >>> 16) : s_reg[c];
        end
        dx0 = 20'(g[1]) - 20'(g[0]);
        dx1 = 20'(g[3]) - 20'(g[2]);

        // stage 9: blend along z
        ax_next = g00_reg + 20'(bl0_reg >>> 16);
        bx      = g01_reg + 20'(bl1_reg >>> 16);
        dy      = 21'(bx) - 21'(ax_next);

        // stage 10 and 11: scale by root two, round and clamp
        r  = ax_reg + 20'(bly_reg >>> 16);
        rr = (rq_reg + 38'sd32768) >>> 16;
        if (rr > 38'sd65536)
        begin
            n_next = 18'sd65536;
        end
        else if (rr < -38'sd65536)
        begin
            n_next = -18'sd65536;
        end
        else
        begin
            n_next = 18'(rr);
        end

        // stage 12: square for ridged, weight by amplitude otherwise
        an = (n_reg < 0) ? -n_reg : n_reg;
        d  = $signed({2'b00, cfg.ridge, 2'b00}) - 19'(an);
        if (ridged)
        begin
            opa = d;
            opb = d;
        end
        else
        begin
            opa = turb ? 19'(an) : 19'(n_reg);
            opb = $signed({2'b00, acc_reg[11].amp});
        end

        // stage 13 and 14: ridged weighting chain, next frequency and amplitude
        n2 = pr12_reg[34:16];
        t1 = n2 * acc_reg[12].amp;
        t2 = term13_reg[35:16] * acc_reg[13].prev;

        // stage 15: accumulate
        fq       = 34'(fp_reg >> 13);
        acc_next = acc_reg[14];
        if (5'(IDX) < cfg.oct)
        begin
            acc_next.sum    = acc_reg[14].sum + (ridged ? (term14_reg >>> 16) : term14_reg);
            acc_next.ampsum = acc_reg[14].ampsum + AMPSUM_W'(acc_reg[14].amp);
            acc_next.prev   = ridged ? n2_14_reg : acc_reg[14].prev;
            acc_next.freq   = (fq > 34'h07FFFFFFF) ? 31'h7FFFFFFF : fq[30:0];
            acc_next.amp    = ap_reg[32:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[1] <= in_acc;
            for (int s = 2; s < NST; s++)
            begin
                acc_reg[s] <= acc_reg[s-1];
            end
            acc_out_reg <= acc_next;

            px_reg <= px_next;
            pz_reg <= pz_next;

            x0_reg    <= x0_next;
            x1_reg    <= x0_next + 32'd1;
            z0_reg    <= z0_next;
            z1_reg    <= z0_next + 32'd1;
            tx_reg[2] <= frac_q16(sx);
            tz_reg[2] <= frac_q16(sz);
            for (int s = 3; s <= 6; s++)
            begin
                tx_reg[s] <= tx_reg[s-1];
                tz_reg[s] <= tz_reg[s-1];
            end

            h1x0_reg <= hash_mix(hs, x0_reg, HASH_C2);
            h1x1_reg <= hash_mix(hs, x1_reg, HASH_C2);
            z0d_reg  <= z0_reg;
            z1d_reg  <= z1_reg;
            p1x_reg  <= p1x_next;
            p1z_reg  <= p1z_next;

            for (int c = 0; c < 4; c++)
            begin
                h4_reg[c] <= h2[c] ^ (h2[c] >> 16);
                h5_reg[c] <= h4_reg[c] * HASH_C4;
                h6_reg[c] <= (h5_reg[c] ^ (h5_reg[c] >> 15)) * HASH_C5;
                s_reg[c]  <= s_next[c];
                dg_reg[c] <= dg_next[c];
                pd_reg[c] <= pd_next[c];
            end
            p2x_reg <= p2x_next;
            p2z_reg <= p2z_next;
            p3x_reg <= p3x_next;
            p3z_reg <= p3z_next;
            p4x_reg <= p4x_next;
            p4z_reg <= p4z_next;
            u_reg   <= u_next;
            v7_reg  <= v_next;

            g00_reg <= 20'(g[0]);
            g01_reg <= 20'(g[2]);
            bl0_reg <= dx0 * $signed({1'b0, u_reg});
            bl1_reg <= dx1 * $signed({1'b0, u_reg});
            v8_reg  <= v7_reg;

            ax_reg  <= ax_next;
            bly_reg <= dy * $signed({1'b0, v8_reg});
            rq_reg  <= r * $signed({1'b0, 17'd92682});
            n_reg   <= n_next;

            pr12_reg   <= opa * opb;
            n2_13_reg  <= n2;
            term13_reg <= ridged ? $signed({4'b0000, t1}) : 40'(pr12_reg);
            n2_14_reg  <= n2_13_reg;
            term14_reg <= ridged ? $signed({1'b0, t2}) : term13_reg;
            fp_reg     <= acc_reg[13].freq * cfg.lac;
            ap_reg     <= acc_reg[13].amp * cfg.gain;
        end
    end

    assign out_valid = vld_reg[NST];
    assign out_acc   = acc_out_reg;

endmodule

### sv/fgn_divide.sv
// ----------------------------------------------------------------------------
// fgn_divide
// Final normalize: rounded divide by four times the amplitude sum, or ridged scaling.
// ----------------------------------------------------------------------------
module fgn_divide
    import fgn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  cfg_t               cfg,
    input  logic               in_valid,
    input  acc_t               in_acc,
    output logic               out_valid,
    output logic signed [15:0] out_value
);

    localparam int QB = 15;

    typedef struct packed {
        logic               neg;
        logic               zero;
        logic               ridged;
        logic signed [15:0] rval;
    } div_flag_t;

    logic [QB:0]         vld_reg;
    logic [SUM_W-1:0]    rem_reg  [0:QB];
    logic [QB-1:0]       q_reg    [0:QB];
    logic [22:0]         den_reg  [0:QB];
    div_flag_t           flag_reg [0:QB];
    logic                out_valid_reg;
    logic signed [15:0]  out_value_reg;

    logic [SUM_W-1:0]    mag;
    logic signed [SUM_W-1:0] rs;
    div_flag_t           flag_next;
    logic [SUM_W-1:0]    rem_next [1:QB];
    logic [QB-1:0]       q_next   [1:QB];
    logic [SUM_W-1:0]    dsh;
    logic [QB-1:0]       qc;
    logic signed [15:0]  value_next;

    always_comb
    begin
        flag_next.neg    = in_acc.sum < 0;
        flag_next.zero   = (in_acc.ampsum == '0) || (cfg.mode > MODE_RIDGED);
        flag_next.ridged = (cfg.mode == MODE_RIDGED);
        mag = flag_next.neg ? SUM_W'(-in_acc.sum) : SUM_W'(in_acc.sum);
        rs  = (in_acc.sum + SUM_W'(2)) >>> 2;
        if (rs < 0)
        begin
            flag_next.rval = 16'sd0;
        end
        else if (rs > SUM_W'(16384))
        begin
            flag_next.rval = 16'sd16384;
        end
        else
        begin
            flag_next.rval = 16'(rs);
        end

        // one quotient bit per stage, most significant first
        for (int s = 1; s <= QB; s++)
        begin
            dsh = SUM_W'(den_reg[s-1]) << (QB - s);
            rem_next[s] = rem_reg[s-1];
            q_next[s]   = q_reg[s-1];
            if (rem_reg[s-1] >= dsh)
            begin
                rem_next[s]        = rem_reg[s-1] - dsh;
                q_next[s][QB - s]  = 1'b1;
            end
        end

        qc = (q_reg[QB] > QB'(16384)) ? QB'(16384) : q_reg[QB];
        if (flag_reg[QB].ridged)
        begin
            value_next = flag_reg[QB].rval;
        end
        else if (flag_reg[QB].zero)
        begin
            value_next = 16'sd0;
        end
        else if (flag_reg[QB].neg)
        begin
            value_next = -$signed({1'b0, qc});
        end
        else
        begin
            value_next = $signed({1'b0, qc});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[QB-1:0], in_valid};
            out_valid_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= mag + SUM_W'({in_acc.ampsum, 1'b0});
            q_reg[0]    <= '0;
            den_reg[0]  <= {in_acc.ampsum, 2'b00};
            flag_reg[0] <= flag_next;
            for (int s = 1; s <= QB; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                q_reg[s]    <= q_next[s];
                den_reg[s]  <= den_reg[s-1];
                flag_reg[s] <= flag_reg[s-1];
            end
            out_value_reg <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

endmodule

### sv/fractal_gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d
// Layered 2D gradient noise (fractal sum, turbulence, ridged), Q16.16 in,
// Q2.14 out.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  in      | in_valid / in_ready    | x_coord, z_coord
//  out     | out_valid / out_ready  | noise_value
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One sample enters per cycle unless the pipe holds. The path is one entry
//  register, a 15-stage pipeline per octave unit and a 17-stage normalize
//  with a one-bit-per-stage divider.
//  The whole pipe advances together; it holds while out_valid waits on
//  out_ready, and in_ready follows that hold.
//  Reset clears valid bits and loads register defaults; cfg_ready is high.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d
    import fgn_pkg::*;
#(
    parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] z_coord,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] noise_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [1:0]  mode_reg;
    logic [3:0]  oct_reg;
    logic [15:0] lac_reg;
    logic [15:0] gain_reg;
    logic [14:0] ridge_reg;
    logic [31:0] seed_reg;

    cfg_t  cfg;
    logic  en;
    logic  v0_reg;
    acc_t  acc0_reg;
    acc_t  acc0_next;
    logic  vld  [0:MAX_OCTAVES];
    acc_t  acc  [0:MAX_OCTAVES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FRACTAL;
            oct_reg   <= 4'd4;
            lac_reg   <= 16'd8192;
            gain_reg  <= 16'd32768;
            ridge_reg <= 15'd16384;
            seed_reg  <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_OCT:   oct_reg   <= cfg_data[3:0];
                REG_LAC:   lac_reg   <= cfg_data[15:0];
                REG_GAIN:  gain_reg  <= cfg_data[15:0];
                REG_RIDGE: ridge_reg <= cfg_data[14:0];
                REG_SEED:  seed_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        cfg.mode  = mode_reg;
        cfg.oct   = ({1'b0, oct_reg} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, oct_reg};
        cfg.lac   = lac_reg;
        cfg.gain  = gain_reg;
        cfg.ridge = ridge_reg;
        cfg.seed  = seed_reg;

        acc0_next.x      = x_coord;
        acc0_next.z      = z_coord;
        acc0_next.freq   = 31'h10000;
        acc0_next.amp    = (mode_reg == MODE_RIDGED) ? 17'd32768 : 17'd65536;
        acc0_next.prev   = 19'd65536;
        acc0_next.sum    = '0;
        acc0_next.ampsum = '0;
    end

    // advance unless a finished result is waiting
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc0_reg <= acc0_next;
        end
    end

    assign vld[0] = v0_reg;
    assign acc[0] = acc0_reg;

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_oct
        fgn_octave #(
            .IDX             (i),
            .COORD_FRAC_BITS (COORD_FRAC_BITS)
        ) u_oct (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .cfg       (cfg),
            .in_valid  (vld[i]),
            .in_acc    (acc[i]),
            .out_valid (vld[i+1]),
            .out_acc   (acc[i+1])
        );
    end

    fgn_divide u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (vld[MAX_OCTAVES]),
        .in_acc    (acc[MAX_OCTAVES]),
        .out_valid (out_valid),
        .out_value (noise_value)
    );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the layered gradient noise block: random and
// directed points under several register settings, checked against an
// in-bench fixed-point noise calculator.
// ----------------------------------------------------------------------------
module tb;
    import fgn_pkg::*;

    localparam int MAXO = 8;
    localparam int FRACB = 16;
    localparam int LATENCY = 15 * MAXO + 18;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] z;
    } point_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] z_coord;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] noise_value;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    // register shadow
    logic [1:0] sh_mode;
    logic [3:0] sh_oct;
    logic [15:0] sh_lac;
    logic [15:0] sh_gain;
    logic [14:0] sh_ridge;
    logic [31:0] sh_seed;

    point_t point_q[$];
    logic signed [15:0] noise_q[$];
    int mismatches;
    int received;
    bit quiet;
    bit hold_long;
    int hold_cnt;
    int in_gap;
    int out_gap;
    bit stall_done;

    fractal_gradient_noise_2d DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .x_coord(x_coord), .z_coord(z_coord),
        .out_valid(out_valid), .out_ready(out_ready),
        .noise_value(noise_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [31:0] corner_hash(logic [31:0] x, logic [31:0] z,
                                                logic [31:0] s);
        logic [31:0] h;
        h = s + 32'h9e3779b9;
        h = h ^ (x + 32'h85ebca6b + (h << 6) + (h >> 2));
        h = h ^ (z + 32'hc2b2ae35 + (h << 6) + (h >> 2));
        h = h ^ (h >> 16);
        h = h * 32'h7feb352d;
        h = h ^ (h >> 15);
        h = h * 32'h846ca68b;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic longint diag_dot(longint s);
        return floor_shr(s * 46341 + 32768, 16);
    endfunction

    function automatic longint grad_dot(logic [31:0] h, longint a, longint b);
        case (h[2:0])
            3'd0: return a;
            3'd1: return -a;
            3'd2: return b;
            3'd3: return -b;
            3'd4: return diag_dot(a + b);
            3'd5: return diag_dot(b - a);
            3'd6: return diag_dot(a - b);
            default: return diag_dot(-a - b);
        endcase
    endfunction

    function automatic longint fade(longint t);
        longint b;
        b = floor_shr((6 * t - 15 * 65536) * t, 16) + 10 * 65536;
        b = floor_shr(b * t, 16);
        b = floor_shr(b * t, 16);
        b = floor_shr(b * t, 16);
        return clip(b, 0, 65536);
    endfunction

    function automatic longint mix(longint a, longint b, longint w);
        return a + floor_shr((b - a) * w, 16);
    endfunction

    function automatic longint lattice_noise(longint sx, longint sz, logic [31:0] s);
        logic [31:0] x0;
        logic [31:0] z0;
        longint tx;
        longint tz;
        longint u;
        longint v;
        longint n00;
        longint n10;
        longint n01;
        longint n11;
        longint r;
        x0 = 32'(floor_shr(sx, FRACB));
        z0 = 32'(floor_shr(sz, FRACB));
        tx = sx & ((64'd1 << FRACB) - 1);
        tz = sz & ((64'd1 << FRACB) - 1);
        u = fade(tx);
        v = fade(tz);
        n00 = grad_dot(corner_hash(x0, z0, s), tx, tz);
        n10 = grad_dot(corner_hash(x0 + 1, z0, s), tx - 65536, tz);
        n01 = grad_dot(corner_hash(x0, z0 + 1, s), tx, tz - 65536);
        n11 = grad_dot(corner_hash(x0 + 1, z0 + 1, s), tx - 65536, tz - 65536);
        r = mix(mix(n00, n10, u), mix(n01, n11, u), v);
        r = floor_shr(r * 92682 + 32768, 16);
        return clip(r, -65536, 65536);
    endfunction

    function automatic logic signed [15:0] layered_noise(point_t p);
        longint freq;
        longint amp;
        longint prev;
        longint sum;
        longint ampsum;
        longint res;
        longint n;
        longint d;
        longint n2;
        longint m;
        longint q;
        longint sx;
        longint sz;
        int oct;
        oct = sh_oct > MAXO ? MAXO : sh_oct;
        freq = 65536;
        amp = sh_mode == MODE_RIDGED ? 32768 : 65536;
        prev = 65536;
        sum = 0;
        ampsum = 0;
        res = 0;
        if (sh_mode <= MODE_RIDGED)
        begin
            for (int i = 0; i < oct; i++)
            begin
                sx = clip(floor_shr(longint'(p.x) * freq, 16), -64'sd2147483648, 2147483647);
                sz = clip(floor_shr(longint'(p.z) * freq, 16), -64'sd2147483648, 2147483647);
                n = lattice_noise(sx, sz, sh_seed + 32'(i));
                if (sh_mode == MODE_RIDGED)
                begin
                    d = longint'(sh_ridge) * 4 - (n < 0 ? -n : n);
                    n2 = floor_shr(d * d, 16);
                    sum += floor_shr(floor_shr(n2 * amp, 16) * prev, 16);
                    prev = n2;
                end
                else
                begin
                    if (sh_mode == MODE_TURB && n < 0)
                        n = -n;
                    sum += n * amp;
                    ampsum += amp;
                end
                amp = floor_shr(amp * longint'(sh_gain), 16);
                freq = (freq * longint'(sh_lac)) >>> 13;
                if (freq > 64'h7FFFFFFF)
                    freq = 64'h7FFFFFFF;
            end
            if (sh_mode == MODE_RIDGED)
                res = clip(floor_shr(sum + 2, 2), 0, 16384);
            else if (ampsum > 0)
            begin
                m = sum < 0 ? -sum : sum;
                q = (m + (ampsum * 4) / 2) / (ampsum * 4);
                res = clip(sum < 0 ? -q : q, -16384, 16384);
            end
        end
        return 16'(res);
    endfunction

    // driver: one transfer per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x_coord <= '0;
            z_coord <= '0;
            in_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid && in_ready)
                noise_q.push_back(layered_noise({x_coord, z_coord}));
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (point_q.size() > 0)
            begin
                in_valid <= 1'b1;
                {x_coord, z_coord} <= point_q.pop_front();
                if (!quiet && $urandom_range(0, 5) == 0)
                    in_gap <= $urandom_range(1, 4);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted separately
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_long)
            hold_cnt <= 300;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                received <= received + 1;
                if (noise_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected noise_value %0d", noise_value);
                end
                else
                begin
                    want = noise_q.pop_front();
                    if (want !== noise_value)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("noise_value mismatch: expected %0d got %0d",
                                     want, noise_value);
                    end
                end
            end
            if (hold_long || hold_cnt > 1)
                out_ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    out_gap <= $urandom_range(1, 4);
            end
        end
    end

    task automatic wait_drained();
        while (point_q.size() > 0 || in_valid || noise_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        // leave the bus idle before the next write
        @(posedge clk);
        case (idx)
            REG_MODE: sh_mode = val[1:0];
            REG_OCT: sh_oct = val[3:0];
            REG_LAC: sh_lac = val[15:0];
            REG_GAIN: sh_gain = val[15:0];
            REG_RIDGE: sh_ridge = val[14:0];
            default: sh_seed = val;
        endcase
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
            2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 65536)
                                           : 32'sh80000000 + $urandom_range(0, 65536);
            default: return $signed($urandom_range(0, 1023)) <<< $urandom_range(0, 20);
        endcase
    endfunction

    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
            point_q.push_back({rand_coord(), rand_coord()});
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        received = 0;
        quiet = 1'b0;
        hold_long = 1'b0;
        stall_done = 1'b0;
        sh_mode = MODE_FRACTAL;
        sh_oct = 4;
        sh_lac = 8192;
        sh_gain = 32768;
        sh_ridge = 16384;
        sh_seed = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes under reset defaults
        point_q.push_back({32'sh00000000, 32'sh00000000});
        point_q.push_back({32'sh7FFFFFFF, 32'sh7FFFFFFF});
        point_q.push_back({32'sh80000000, 32'sh80000000});
        point_q.push_back({32'sh7FFFFFFF, 32'sh80000000});
        point_q.push_back({32'shFFFFFFFF, 32'sh0000FFFF});
        point_q.push_back({32'sh00018000, 32'shFFFE8000});
        point_q.push_back({32'sh55555555, 32'shAAAAAAAA});
        wait_drained();

        // saturated octave count, large frequency, mode without meaning
        write_reg(REG_OCT, 15);
        write_reg(REG_LAC, 16'hFFFF);
        write_reg(REG_SEED, 32'hFFFFFFFF);
        point_q.push_back({32'sh12345678, 32'shEDCBA987});
        point_q.push_back({32'sh80000000, 32'sh7FFFFFFF});
        random_points(3);
        wait_drained();
        write_reg(REG_MODE, 3);
        random_points(3);
        wait_drained();
        write_reg(REG_OCT, 0);
        write_reg(REG_MODE, MODE_FRACTAL);
        random_points(3);
        wait_drained();
        write_reg(REG_LAC, 0);
        write_reg(REG_OCT, 8);
        write_reg(REG_GAIN, 16'hFFFF);
        random_points(3);
        wait_drained();
        write_reg(REG_MODE, MODE_RIDGED);
        write_reg(REG_RIDGE, 15'h7FFF);
        random_points(3);
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_MODE, ph % 3);
            write_reg(REG_OCT, ph == 7 ? 8 : $urandom_range(1, 9));
            write_reg(REG_LAC, ph == 2 ? 16'h0000 : $urandom_range(8192, 20000));
            write_reg(REG_GAIN, ph == 3 ? 16'h0000 : $urandom());
            write_reg(REG_RIDGE, ph == 4 ? 15'h0000 : $urandom());
            write_reg(REG_SEED, $urandom());
            if (ph == 7)
                quiet = 1'b1;
            random_points(48);
            if (ph == 1 && !stall_done)
            begin
                // hold off the receiver while the sender keeps offering points
                @(posedge clk);
                hold_long <= 1'b1;
                @(posedge clk);
                hold_long <= 1'b0;
                stall_done = 1'b1;
            end
            wait_drained();
        end

        $display("covered %0d results over fractal, turbulence and ridged settings,", received);
        $display("including zero and saturated octave counts and extreme coordinates");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end
endmodule

### fractal_gradient_noise_2d.f
sv/fgn_pkg.sv
sv/fgn_octave.sv
sv/fgn_divide.sv
sv/fractal_gradient_noise_2d.sv
sim/tb.sv
